// ----- design/fbfla_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbfla_pkg
// shared types and codes for the fixed block free list allocator
// ----------------------------------------------------------------------------
package fbfla_pkg;

    localparam int CFG_WIDTH = 16;
    localparam logic [CFG_WIDTH-1:0] BLOCK_BYTES_RESET = 16'd64;

    // command codes
    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_RESIZE = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    // status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_EMPTY     = 2'd1;
    localparam logic [1:0] STS_TOO_LARGE = 2'd2;
    localparam logic [1:0] STS_NO_LIVE   = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  block_index;
        logic [31:0] requested_bytes;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  granted_index;
        logic [21:0] bytes_in_use;
        logic [6:0]  live_count;
    } out_item_t;

    typedef enum logic [1:0] {
        STATE_INIT,
        STATE_IDLE,
        STATE_ALLOC_RD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic sweep_wr;
        logic accept;
        logic alloc_commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic out_busy;
        logic alloc_go;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- design/fbfla_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbfla_ctrl
// sequencer: link init sweep, transaction accept, two-step allocate
// ----------------------------------------------------------------------------
module fbfla_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire fbfla_pkg::dp_stat_t stat,
    output fbfla_pkg::dp_cmd_t      cmd
);
    import fbfla_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == STATE_IDLE) && !stat.out_busy;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            STATE_INIT: begin
                if (stat.sweep_last) begin
                    state_next = STATE_IDLE;
                end
            end
            STATE_IDLE: begin
                if (accept && stat.alloc_go) begin
                    state_next = STATE_ALLOC_RD;
                end
            end
            STATE_ALLOC_RD: begin
                state_next = STATE_IDLE;
            end
            default: begin
                state_next = STATE_INIT;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            STATE_INIT: begin
                cmd.sweep_wr = 1'b1;
            end
            STATE_IDLE: begin
                cmd.accept = accept;
            end
            STATE_ALLOC_RD: begin
                cmd.alloc_commit = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/fbfla_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbfla_dp
// link memory, free list head, counters, config register and result register
// ----------------------------------------------------------------------------
module fbfla_dp #(
    parameter int NUM_BLOCKS = 64
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [15:0]               cfg_wr_data,
    input  wire fbfla_pkg::in_item_t       s_data,
    output fbfla_pkg::out_item_t           m_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    input  wire fbfla_pkg::dp_cmd_t        cmd,
    output fbfla_pkg::dp_stat_t            stat
);
    import fbfla_pkg::*;

    localparam int LW = $clog2(NUM_BLOCKS + 1);
    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(NUM_BLOCKS);
    localparam logic [LW-1:0] LAST_IDX  = LW'(NUM_BLOCKS - 1);

    logic [LW-1:0] link_mem [NUM_BLOCKS];
    logic [LW-1:0] rd_data_reg;

    logic [LW-1:0]        head_reg, head_next;
    logic [31:0]          live_reg, live_next;
    logic [21:0]          used_reg, used_next;
    logic [CFG_WIDTH-1:0] blk_bytes_reg;
    logic [LW-1:0]        sweep_cnt_reg;
    out_item_t            out_reg, out_next;
    logic                 out_valid_reg;
    logic                 out_load;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [LW-1:0] wr_data;

    logic head_empty;
    logic idx_in_range;

    assign head_empty   = (head_reg >= NULL_LINK);
    assign idx_in_range = (32'(s_data.block_index) < 32'(NUM_BLOCKS));

    assign stat.sweep_last = (sweep_cnt_reg == LAST_IDX);
    assign stat.out_busy   = out_valid_reg && !m_ready;
    assign stat.alloc_go   = (s_data.cmd == CMD_ALLOC) && !head_empty;

    assign m_data  = out_reg;
    assign m_valid = out_valid_reg;

    // link memory, read port always looks at the current head
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= link_mem[head_reg[IW-1:0]];
    end

    always_comb begin
        head_next = head_reg;
        live_next = live_reg;
        used_next = used_reg;
        out_next  = out_reg;
        out_load  = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = sweep_cnt_reg[IW-1:0];
        wr_data   = sweep_cnt_reg + LW'(1);

        if (cmd.sweep_wr) begin
            wr_en = 1'b1;
        end else if (cmd.alloc_commit) begin
            head_next = rd_data_reg;
            live_next = live_reg + 32'd1;
            used_next = used_reg + 22'(blk_bytes_reg);
            out_load  = 1'b1;
            out_next.status        = STS_OK;
            out_next.granted_index = 6'(head_reg);
            out_next.bytes_in_use  = used_next;
            out_next.live_count    = live_next[6:0];
        end else if (cmd.accept) begin
            out_next.status        = STS_OK;
            out_next.granted_index = '0;
            case (s_data.cmd)
                CMD_ALLOC: begin
                    // nonempty allocate finishes in the next cycle
                    out_load        = head_empty;
                    out_next.status = STS_EMPTY;
                end
                CMD_FREE: begin
                    out_load = 1'b1;
                    if (live_reg == 32'd0) begin
                        out_next.status = STS_NO_LIVE;
                    end else if (idx_in_range) begin
                        wr_en     = 1'b1;
                        wr_addr   = IW'(s_data.block_index);
                        wr_data   = head_reg;
                        head_next = LW'(s_data.block_index);
                        live_next = live_reg - 32'd1;
                        used_next = used_reg - 22'(blk_bytes_reg);
                    end
                end
                CMD_RESIZE: begin
                    out_load = 1'b1;
                    if (s_data.requested_bytes <= 32'(blk_bytes_reg)) begin
                        out_next.granted_index = s_data.block_index;
                    end else begin
                        out_next.status = STS_TOO_LARGE;
                    end
                end
                default: begin
                    out_load = 1'b1;
                end
            endcase
            out_next.bytes_in_use = used_next;
            out_next.live_count   = live_next[6:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            live_reg      <= '0;
            used_reg      <= '0;
            blk_bytes_reg <= BLOCK_BYTES_RESET;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg <= head_next;
            live_reg <= live_next;
            used_reg <= used_next;
            if (cfg_wr_en) begin
                blk_bytes_reg <= cfg_wr_data;
            end
            if (cmd.sweep_wr) begin
                sweep_cnt_reg <= sweep_cnt_reg + LW'(1);
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/fixed_block_free_list_allocator_top.sv -----
`default_nettype none
// results: free, resize, no-op and empty-pool allocate results are registered
//   and appear in the cycle after acceptance; a nonempty allocate first does a
//   registered read of the link memory at the head, holding s_ready low meanwhile
// reset: synchronous active-low; afterwards the link memory is initialized by
//   a sweep over all blocks during which s_ready stays low
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top
// pool of NUM_BLOCKS fixed-size blocks managed as a lifo free list
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_top #(
    parameter int NUM_BLOCKS = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // config: block size in bytes
    input  wire logic                cfg_wr_en,
    input  wire logic [15:0]         cfg_wr_data,
    // command transactions
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire fbfla_pkg::in_item_t s_data,
    // result transactions
    output logic                     m_valid,
    input  wire logic                m_ready,
    output fbfla_pkg::out_item_t     m_data
);
    import fbfla_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // controller: init sweep, accept gating, two-step allocate sequencing
    fbfla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    // datapath: link memory, head pointer, live count, byte usage, result reg
    fbfla_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_data      (m_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (dp_cmd),
        .stat        (dp_stat)
    );

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fixed block free list allocator: a mirror of the
// lifo free list predicts status, granted block, bytes in use and live count
// for every command transaction, and each result transaction is compared with
// the oldest prediction. directed corner cases come first, then a pool drain,
// randomized alloc/free/resize traffic under three backpressure mixes, and a
// self-linked list that forces the live count and byte count to wrap
// ----------------------------------------------------------------------------
module tb_top;
    import fbfla_pkg::*;

    localparam int         POOL_BLOCKS  = 64;
    localparam logic [6:0] LINK_NULL    = 7'(POOL_BLOCKS);
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_SETTLE = 4;
    localparam int         MAX_REPORTS  = 10;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = BLOCK_BYTES_RESET;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    in_item_t    s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    out_item_t   m_data;

    // mirror of the pool state
    logic [6:0]  link_mirror [POOL_BLOCKS];
    logic [6:0]  head_mirror;
    logic [31:0] live_mirror;
    logic [21:0] used_mirror;
    logic [15:0] size_mirror;

    out_item_t   awaited_results [$];
    logic [5:0]  held_blocks [$];

    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;
    int unsigned src_idle_pct = 16;
    int unsigned dst_idle_pct = 45;

    fixed_block_free_list_allocator_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stalls at random according to the current mix
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // one command against the mirror, returns the result it should produce
    function automatic out_item_t predict_pool_result(input in_item_t cmd_item);
        out_item_t res;
        res.status        = STS_OK;
        res.granted_index = '0;
        case (cmd_item.cmd)
            CMD_ALLOC: begin
                if (head_mirror >= LINK_NULL) begin
                    res.status = STS_EMPTY;
                end else begin
                    res.granted_index = head_mirror[5:0];
                    head_mirror       = link_mirror[head_mirror[5:0]];
                    live_mirror       = live_mirror + 32'd1;
                    used_mirror       = used_mirror + 22'(size_mirror);
                end
            end
            CMD_FREE: begin
                // a 6-bit index is always inside a 64-block pool
                if (live_mirror == 32'd0) begin
                    res.status = STS_NO_LIVE;
                end else begin
                    link_mirror[cmd_item.block_index] = head_mirror;
                    head_mirror = {1'b0, cmd_item.block_index};
                    live_mirror = live_mirror - 32'd1;
                    used_mirror = used_mirror - 22'(size_mirror);
                end
            end
            CMD_RESIZE: begin
                if (cmd_item.requested_bytes <= 32'(size_mirror))
                    res.granted_index = cmd_item.block_index;
                else
                    res.status = STS_TOO_LARGE;
            end
            default: begin
                // no operation
            end
        endcase
        res.bytes_in_use = used_mirror;
        res.live_count   = live_mirror[6:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic note_failure(input string what, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
    endtask

    // every accepted result transaction is matched against the oldest prediction
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                note_failure("result with nothing awaited, live_count", '0,
                             32'(m_data.live_count));
            end else begin
                want = awaited_results.pop_front();
                if (m_data.status !== want.status)
                    note_failure("status", 32'(want.status), 32'(m_data.status));
                if (m_data.granted_index !== want.granted_index)
                    note_failure("granted_index", 32'(want.granted_index),
                                 32'(m_data.granted_index));
                if (m_data.bytes_in_use !== want.bytes_in_use)
                    note_failure("bytes_in_use", 32'(want.bytes_in_use),
                                 32'(m_data.bytes_in_use));
                if (m_data.live_count !== want.live_count)
                    note_failure("live_count", 32'(want.live_count),
                                 32'(m_data.live_count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic in_item_t make_cmd(input logic [1:0] c, input logic [5:0] blk,
                                          input logic [31:0] req);
        in_item_t it;
        it.cmd             = c;
        it.block_index     = blk;
        it.requested_bytes = req;
        return it;
    endfunction

    // resize request sizes clustered around the current block size
    function automatic logic [31:0] pick_request();
        case ($urandom_range(5))
            0:       return '0;
            1:       return 32'(size_mirror);
            2:       return 32'(size_mirror) + 32'd1;
            3:       return 32'(size_mirror) - 32'd1;
            4:       return $urandom;
            default: return $urandom_range(32'(size_mirror));
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_cmd(input in_item_t it, output out_item_t want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = predict_pool_result(it);
        awaited_results.push_back(want);
        @(negedge aclk);
    endtask

    // hold off until every awaited result has come back and the block is quiet
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_block_size(input logic [15:0] bytes);
        wait_for_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= bytes;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        size_mirror = bytes;
    endtask

    // allocate fields other than cmd are don't-care, so randomize them
    task automatic alloc_block();
        out_item_t want;
        send_cmd(make_cmd(CMD_ALLOC, 6'($urandom), $urandom), want);
        if (want.status == STS_OK)
            held_blocks.push_back(want.granted_index);
    endtask

    // return a block we hold, or a random one when we hold none
    task automatic free_held();
        out_item_t  want;
        int         pos;
        logic [5:0] blk;
        if (held_blocks.size() == 0) begin
            blk = 6'($urandom);
        end else begin
            pos = $urandom_range(held_blocks.size() - 1);
            blk = held_blocks[pos];
            held_blocks.delete(pos);
        end
        send_cmd(make_cmd(CMD_FREE, blk, $urandom), want);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // field extremes, every command, empty-count free, lifo order, size limits
    task automatic test_directed_cases();
        out_item_t want;
        send_cmd(make_cmd(CMD_NOP, 6'd0, 32'h0000_0000), want);
        send_cmd(make_cmd(CMD_NOP, 6'd63, 32'hFFFF_FFFF), want);
        // free with nothing allocated is refused
        send_cmd(make_cmd(CMD_FREE, 6'd5, 32'd0), want);
        // resize against the reset block size
        send_cmd(make_cmd(CMD_RESIZE, 6'd0, 32'd0), want);
        send_cmd(make_cmd(CMD_RESIZE, 6'd63, 32'd64), want);
        send_cmd(make_cmd(CMD_RESIZE, 6'd42, 32'd65), want);
        send_cmd(make_cmd(CMD_RESIZE, 6'd21, 32'hFFFF_FFFF), want);
        // pops come out in list order, a freed block is handed back first
        send_cmd(make_cmd(CMD_ALLOC, 6'd63, 32'hFFFF_FFFF), want);
        send_cmd(make_cmd(CMD_ALLOC, 6'd0, 32'd0), want);
        send_cmd(make_cmd(CMD_ALLOC, 6'd0, 32'd0), want);
        send_cmd(make_cmd(CMD_FREE, 6'd1, 32'd0), want);
        send_cmd(make_cmd(CMD_ALLOC, 6'd0, 32'd0), want);
        // block never handed out is pushed anyway
        send_cmd(make_cmd(CMD_FREE, 6'd63, 32'd0), want);
        send_cmd(make_cmd(CMD_ALLOC, 6'd0, 32'd0), want);
        send_cmd(make_cmd(CMD_FREE, 6'd0, 32'd0), want);
        send_cmd(make_cmd(CMD_FREE, 6'd1, 32'd0), want);
        send_cmd(make_cmd(CMD_FREE, 6'd63, 32'd0), want);
        send_cmd(make_cmd(CMD_FREE, 6'd2, 32'd0), want);
        send_cmd(make_cmd(CMD_FREE, 6'd63, 32'hFFFF_FFFF), want);
        // smallest block size
        set_block_size(16'd1);
        send_cmd(make_cmd(CMD_RESIZE, 6'd9, 32'd1), want);
        send_cmd(make_cmd(CMD_RESIZE, 6'd9, 32'd2), want);
        send_cmd(make_cmd(CMD_ALLOC, 6'd0, 32'd0), want);
        send_cmd(make_cmd(CMD_FREE, want.granted_index, 32'd0), want);
        // largest block size
        set_block_size(16'hFFFF);
        send_cmd(make_cmd(CMD_RESIZE, 6'd54, 32'd65535), want);
        send_cmd(make_cmd(CMD_RESIZE, 6'd54, 32'd65536), want);
        send_cmd(make_cmd(CMD_ALLOC, 6'd0, 32'd0), want);
        send_cmd(make_cmd(CMD_FREE, want.granted_index, 32'd0), want);
    endtask

    // hand out every block, hit the empty pool, then give them all back
    task automatic test_pool_exhaust();
        set_block_size(16'hFFFF);
        repeat (POOL_BLOCKS + 2) alloc_block();
        wait_for_drain();
        while (held_blocks.size() > 0) free_held();
    endtask

    // mostly well-formed alloc/free/resize bursts with some noise mixed in
    task automatic run_random_traffic(input int n_items, input int unsigned src_pct,
                                      input int unsigned dst_pct,
                                      input logic [15:0] bytes);
        int         sent;
        int         pick;
        int         burst;
        logic [5:0] blk;
        in_item_t   noise;
        out_item_t  want;
        set_block_size(bytes);
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                // run the pool dry
                burst = POOL_BLOCKS + 2 - held_blocks.size();
                if (burst < 2)
                    burst = 2;
                repeat (burst) alloc_block();
                sent += burst;
            end else if (pick < 32) begin
                burst = $urandom_range(1, 8);
                repeat (burst) alloc_block();
                sent += burst;
            end else if (pick < 58) begin
                burst = $urandom_range(1, 6);
                repeat (burst) free_held();
                sent += burst;
            end else if (pick < 78) begin
                if (held_blocks.size() > 0 && $urandom_range(3) != 0)
                    blk = held_blocks[$urandom_range(held_blocks.size() - 1)];
                else
                    blk = 6'($urandom);
                send_cmd(make_cmd(CMD_RESIZE, blk, pick_request()), want);
                sent++;
            end else if (pick < 83) begin
                // sender holds off until the block has answered everything
                wait_for_drain();
            end else begin
                // raw transaction, may double free or touch unowned blocks
                noise.cmd             = 2'($urandom_range(3));
                noise.block_index     = 6'($urandom);
                noise.requested_bytes = $urandom;
                send_cmd(noise, want);
                if (noise.cmd == CMD_ALLOC && want.status == STS_OK)
                    held_blocks.push_back(want.granted_index);
                sent++;
            end
        end
    endtask

    // a block freed twice in a row links to itself, so allocate never fails
    // and the live count and byte count run past their widths
    task automatic test_counter_wrap();
        out_item_t  want;
        logic [5:0] loop_blk;
        set_block_size(16'hFFFF);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        while (held_blocks.size() > 0) free_held();
        alloc_block();
        alloc_block();
        loop_blk = (held_blocks.size() > 0) ? held_blocks[0] : 6'd0;
        held_blocks.delete();
        send_cmd(make_cmd(CMD_FREE, loop_blk, 32'd0), want);
        send_cmd(make_cmd(CMD_FREE, loop_blk, 32'd0), want);
        repeat (140) begin
            send_cmd(make_cmd(CMD_ALLOC, 6'($urandom), $urandom), want);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < POOL_BLOCKS; i++)
            link_mirror[i] = 7'(i + 1);
        head_mirror = '0;
        live_mirror = '0;
        used_mirror = '0;
        size_mirror = BLOCK_BYTES_RESET;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // sender idles lightly, receiver heavily
        test_directed_cases();
        test_pool_exhaust();
        run_random_traffic(80, 16, 45, 16'($urandom_range(2, 65534)));
        // roles swapped
        run_random_traffic(80, 45, 16, 16'd1);
        // full rate both sides
        run_random_traffic(80, 0, 0, 16'hFFFF);
        test_counter_wrap();

        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
